[rtl/core/mgvd_pkg.sv]
`timescale 1ns / 1ps

package mgvd_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORM_RANGE_LOW     = 3'd0,
    CFG_NORM_RANGE_HIGH    = 3'd1,
    CFG_PEAK_FORCE         = 3'd2,
    CFG_FORCE_SCALE        = 3'd3,
    CFG_LENGTH_MIN         = 3'd4,
    CFG_LENGTH_MAX         = 3'd5,
    CFG_VELOCITY_MAX       = 3'd6,
    CFG_VELOCITY_FORCE_MAX = 3'd7
  } cfg_idx_t;

  localparam logic signed [DATA_W-1:0] RST_NORM_RANGE_LOW     = 32'sd49152;
  localparam logic signed [DATA_W-1:0] RST_NORM_RANGE_HIGH    = 32'sd68813;
  localparam logic signed [DATA_W-1:0] RST_PEAK_FORCE         = -32'sd65536;
  localparam logic signed [DATA_W-1:0] RST_FORCE_SCALE        = 32'sd13107200;
  localparam logic signed [DATA_W-1:0] RST_LENGTH_MIN         = 32'sd32768;
  localparam logic signed [DATA_W-1:0] RST_LENGTH_MAX         = 32'sd104858;
  localparam logic signed [DATA_W-1:0] RST_VELOCITY_MAX       = 32'sd98304;
  localparam logic signed [DATA_W-1:0] RST_VELOCITY_FORCE_MAX = 32'sd78643;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // force-length curve pieces
  typedef enum logic [1:0] {
    PC_RISE   = 2'd0,
    PC_TOP_LO = 2'd1,
    PC_TOP_HI = 2'd2,
    PC_FALL   = 2'd3
  } fl_piece_t;

  // force-velocity slope source
  typedef enum logic [1:0] {
    DFV_ZERO   = 2'd0,
    DFV_LINEAR = 2'd1,
    DFV_DIV    = 2'd2
  } dfv_sel_t;

endpackage

[rtl/core/mgvd_if.sv]
`timescale 1ns / 1ps

interface mgvd_in_if import mgvd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] muscle_length;
  logic signed [DATA_W-1:0] muscle_velocity;
  logic signed [DATA_W-1:0] length_range_low;
  logic signed [DATA_W-1:0] length_range_high;
  logic signed [DATA_W-1:0] accel_scale;

  modport source (
    output valid, muscle_length, muscle_velocity, length_range_low,
    output length_range_high, accel_scale,
    input  ready
  );
  modport sink (
    input  valid, muscle_length, muscle_velocity, length_range_low,
    input  length_range_high, accel_scale,
    output ready
  );
endinterface

interface mgvd_out_if import mgvd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] gain_slope;

  modport source (output valid, gain_slope, input ready);
  modport sink (input valid, gain_slope, output ready);
endinterface

[rtl/core/mgvd_div.sv]
`timescale 1ns / 1ps

// Pipelined saturating fixed-point divide: sat((n << FRAC_BITS) / max(d, 1)),
// truncated toward zero. One quotient bit per stage.
module mgvd_div import mgvd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] n_i,
  input  logic signed [DATA_W-1:0] d_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] q_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int NW = DATA_W + FRAC_BITS;
  localparam int RW = DATA_W - 1;

  logic [NW-1:0]     nq  [NW+1];
  logic [RW-1:0]     rem [NW+1];
  logic [RW-1:0]     dv  [NW+1];
  logic              neg [NW+1];
  logic              vld [NW+1];
  logic [SIDE_W-1:0] sb  [NW+1];

  logic [DATA_W-1:0] mag;
  logic [RW-1:0]     d_clamp;

  assign mag     = n_i[DATA_W-1] ? DATA_W'(-n_i) : DATA_W'(n_i);
  assign d_clamp = (d_i[DATA_W-1] || d_i == '0) ? RW'(1) : d_i[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]  <= {mag, {FRAC_BITS{1'b0}}};
      rem[0] <= '0;
      dv[0]  <= d_clamp;
      neg[0] <= n_i[DATA_W-1];
      sb[0]  <= side_i;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_step
    logic [RW:0] trial;
    logic        ge;

    assign trial = {rem[k-1], nq[k-1][NW-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[k]  <= {nq[k-1][NW-2:0], ge};
        rem[k] <= ge ? RW'(trial - {1'b0, dv[k-1]}) : trial[RW-1:0];
        dv[k]  <= dv[k-1];
        neg[k] <= neg[k-1];
        sb[k]  <= sb[k-1];
      end
    end
  end

  logic                     over_pos;
  logic                     over_neg;
  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    over_pos = |nq[NW][NW-1:DATA_W-1];
    over_neg = (|nq[NW][NW-1:DATA_W]) ||
               (nq[NW][DATA_W-1] && (|nq[NW][DATA_W-2:0]));
    if (neg[NW]) begin
      q_next = over_neg ? S_MIN : -$signed(nq[NW][DATA_W-1:0]);
    end else begin
      q_next = over_pos ? S_MAX : $signed(nq[NW][DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o    <= q_next;
      side_o <= sb[NW];
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> dv[0] != '0)
    else $error("divisor reached zero after clamp");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[NW] |-> rem[NW] < dv[NW])
    else $error("final remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && valid_o) |=> $stable(q_o) && valid_o)
    else $error("quotient changed during stall");

endmodule

[rtl/core/muscle_gain_velocity_derivative.sv]
`timescale 1ns / 1ps

// Pipeline: four chained levels of bit-per-stage dividers (A to D) plus eleven
// arithmetic stages between input transfer and result. Data is Q16.16 at the default FRAC_BITS.
// Throughput: one item per cycle; the whole pipeline advances on one enable and
// halts only when the result register holds an untaken result.
// Reset (rst, synchronous, active high) clears all valid bits and loads the
// configuration registers with their default values.
module muscle_gain_velocity_derivative import mgvd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  mgvd_in_if.sink           item,
  mgvd_out_if.source        result
);

  localparam int DW = DATA_W;
  localparam int WW = DATA_W + 4;
  localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << FRAC_BITS);

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] v);
    logic [WW-DW:0] top;
    top = v[WW-1:DW-1];
    if ((&top) || !(|top)) begin
      return v[DW-1:0];
    end
    return v[WW-1] ? S_MIN : S_MAX;
  endfunction

  function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    return sat_w(WW'(a) - WW'(b));
  endfunction

  // product shifted right with floor, then saturated
  function automatic logic signed [DW-1:0] mulsat(input logic signed [2*DW-1:0] p);
    logic signed [2*DW-1:0] s;
    logic [DW:0]            top;
    s   = p >>> FRAC_BITS;
    top = s[2*DW-1:DW-1];
    if ((&top) || !(|top)) begin
      return s[DW-1:0];
    end
    return s[2*DW-1] ? S_MIN : S_MAX;
  endfunction

  function automatic logic signed [DW-1:0] atleast1(input logic signed [DW-1:0] v);
    return (v[DW-1] || v == '0) ? DW'(1) : v;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] nr_lo, nr_hi, pk_force, f_scale;
  logic signed [DW-1:0] l_min, l_max, v_max, vf_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      nr_lo    <= RST_NORM_RANGE_LOW;
      nr_hi    <= RST_NORM_RANGE_HIGH;
      pk_force <= RST_PEAK_FORCE;
      f_scale  <= RST_FORCE_SCALE;
      l_min    <= RST_LENGTH_MIN;
      l_max    <= RST_LENGTH_MAX;
      v_max    <= RST_VELOCITY_MAX;
      vf_max   <= RST_VELOCITY_FORCE_MAX;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NORM_RANGE_LOW:     nr_lo    <= $signed(cfg_data);
        CFG_NORM_RANGE_HIGH:    nr_hi    <= $signed(cfg_data);
        CFG_PEAK_FORCE:         pk_force <= $signed(cfg_data);
        CFG_FORCE_SCALE:        f_scale  <= $signed(cfg_data);
        CFG_LENGTH_MIN:         l_min    <= $signed(cfg_data);
        CFG_LENGTH_MAX:         l_max    <= $signed(cfg_data);
        CFG_VELOCITY_MAX:       v_max    <= $signed(cfg_data);
        CFG_VELOCITY_FORCE_MAX: vf_max   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Curve breakpoints and force-velocity offset depend on configuration only, which the user
  // must keep static while items are in flight; the block itself does not enforce it.
  logic signed [DW-1:0] a_mid, b_mid, y_off;
  logic signed [WW-1:0] a_sum, b_sum;

  assign a_sum = WW'(l_min) + WW'(ONE_Q);
  assign b_sum = WW'(ONE_Q) + WW'(l_max);
  assign a_mid = sat_w(a_sum >>> 1);
  assign b_mid = sat_w(b_sum >>> 1);
  assign y_off = sub_sat(vf_max, ONE_Q);

  // ---------------------------------------------------------------------
  // Global advance: every stage moves together unless the result register
  // holds a result that the sink has not taken.
  // ---------------------------------------------------------------------
  logic                 en;
  logic                 out_v;
  logic signed [DW-1:0] out_q;

  assign en          = !out_v || result.ready;
  assign item.ready  = en;
  assign result.valid      = out_v;
  assign result.gain_slope = out_q;

  typedef struct packed {
    logic signed [DW-1:0] len;
    logic signed [DW-1:0] vel;
    logic signed [DW-1:0] lrl;
  } a_side_t;

  typedef struct packed {
    logic signed [DW-1:0] force_v;
    logic signed [DW-1:0] vden;
  } b_side_t;

  typedef struct packed {
    logic signed [DW-1:0] force_v;
    logic signed [DW-1:0] vden;
    logic                 in_rng;
    fl_piece_t            piece;
    dfv_sel_t             dsel;
    logic signed [DW-1:0] dlin;
  } c_side_t;

  // ---------------------------------------------------------------------
  // Divide A: peak force from scale, and optimal length
  // ---------------------------------------------------------------------
  a_side_t              a_side_in, a_side;
  logic                 a_v;
  logic signed [DW-1:0] a_force_q, a_l0_q;

  assign a_side_in = '{len: item.muscle_length, vel: item.muscle_velocity,
                       lrl: item.length_range_low};

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(a_side_t))) u_div_force (
    .clk(clk), .rst(rst), .en(en), .valid_i(item.valid),
    .n_i(f_scale), .d_i(item.accel_scale), .side_i(a_side_in),
    .valid_o(a_v), .q_o(a_force_q), .side_o(a_side)
  );

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_l0 (
    .clk(clk), .rst(rst), .en(en), .valid_i(item.valid),
    .n_i(sub_sat(item.length_range_high, item.length_range_low)),
    .d_i(sub_sat(nr_hi, nr_lo)), .side_i(1'b0),
    .valid_o(), .q_o(a_l0_q), .side_o()
  );

  // ---------------------------------------------------------------------
  // M1: pick force, form length numerator, multiply l0 by velocity limit
  // M2: velocity denominator
  // ---------------------------------------------------------------------
  logic                   m1_v, m2_v;
  logic signed [DW-1:0]   m1_force, m1_lnum, m1_vel, m1_l0;
  logic signed [2*DW-1:0] m1_prod;
  logic signed [DW-1:0]   m2_force, m2_lnum, m2_vel, m2_l0, m2_vden;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_force <= pk_force[DW-1] ? a_force_q : pk_force;
      m1_lnum  <= sub_sat(a_side.len, a_side.lrl);
      m1_vel   <= a_side.vel;
      m1_l0    <= a_l0_q;
      m1_prod  <= a_l0_q * v_max;

      m2_force <= m1_force;
      m2_lnum  <= m1_lnum;
      m2_vel   <= m1_vel;
      m2_l0    <= m1_l0;
      m2_vden  <= atleast1(mulsat(m1_prod));
    end
  end

  // ---------------------------------------------------------------------
  // Divide B: normalized length offset and normalized velocity
  // ---------------------------------------------------------------------
  b_side_t              b_side;
  logic                 b_v;
  logic signed [DW-1:0] b_q1, b_vn;

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(b_side_t))) u_div_len (
    .clk(clk), .rst(rst), .en(en), .valid_i(m2_v),
    .n_i(m2_lnum), .d_i(m2_l0),
    .side_i(b_side_t'{force_v: m2_force, vden: m2_vden}),
    .valid_o(b_v), .q_o(b_q1), .side_o(b_side)
  );

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_vel (
    .clk(clk), .rst(rst), .en(en), .valid_i(m2_v),
    .n_i(m2_vel), .d_i(m2_vden), .side_i(1'b0),
    .valid_o(), .q_o(b_vn), .side_o()
  );

  // ---------------------------------------------------------------------
  // P1: normalized length.  P2: curve piece and slope branch selection.
  // ---------------------------------------------------------------------
  logic                 p1_v, p2_v;
  logic signed [DW-1:0] p1_lnorm, p1_vnorm, p1_force, p1_vden;

  logic                 p2_in_rng;
  fl_piece_t            p2_piece;
  dfv_sel_t             p2_dsel;
  logic signed [DW-1:0] p2_xn, p2_xd, p2_dlin, p2_dnum, p2_force, p2_vden;

  logic                 in_rng_c;
  fl_piece_t            piece_c;
  dfv_sel_t             dsel_c;
  logic signed [DW-1:0] xn_c, xd_c;

  always_comb begin
    in_rng_c = (p1_lnorm >= l_min) && (p1_lnorm <= l_max);
    if (p1_lnorm <= a_mid) begin
      piece_c = PC_RISE;
      xn_c    = sub_sat(p1_lnorm, l_min);
      xd_c    = sub_sat(a_mid, l_min);
    end else if (p1_lnorm <= ONE_Q) begin
      piece_c = PC_TOP_LO;
      xn_c    = sub_sat(ONE_Q, p1_lnorm);
      xd_c    = sub_sat(ONE_Q, a_mid);
    end else if (p1_lnorm <= b_mid) begin
      piece_c = PC_TOP_HI;
      xn_c    = sub_sat(p1_lnorm, ONE_Q);
      xd_c    = sub_sat(b_mid, ONE_Q);
    end else begin
      piece_c = PC_FALL;
      xn_c    = sub_sat(l_max, p1_lnorm);
      xd_c    = sub_sat(l_max, b_mid);
    end

    if (p1_vnorm <= -ONE_Q) begin
      dsel_c = DFV_ZERO;
    end else if (p1_vnorm[DW-1] || p1_vnorm == '0) begin
      dsel_c = DFV_LINEAR;
    end else if (p1_vnorm <= y_off) begin
      dsel_c = DFV_DIV;
    end else begin
      dsel_c = DFV_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_lnorm  <= sat_w(WW'(nr_lo) + WW'(b_q1));
      p1_vnorm  <= b_vn;
      p1_force  <= b_side.force_v;
      p1_vden   <= b_side.vden;

      p2_in_rng <= in_rng_c;
      p2_piece  <= piece_c;
      p2_dsel   <= dsel_c;
      p2_xn     <= xn_c;
      p2_xd     <= xd_c;
      p2_dlin   <= sat_w(2 * WW'(p1_vnorm) + 2 * WW'(ONE_Q));
      p2_dnum   <= sat_w(2 * WW'(y_off) - 2 * WW'(p1_vnorm));
      p2_force  <= p1_force;
      p2_vden   <= p1_vden;
    end
  end

  // ---------------------------------------------------------------------
  // Divide C: curve abscissa and velocity slope quotient
  // ---------------------------------------------------------------------
  c_side_t              c_side;
  logic                 c_v;
  logic signed [DW-1:0] c_x, c_dq;

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(c_side_t))) u_div_x (
    .clk(clk), .rst(rst), .en(en), .valid_i(p2_v),
    .n_i(p2_xn), .d_i(p2_xd),
    .side_i(c_side_t'{force_v: p2_force, vden: p2_vden, in_rng: p2_in_rng,
                      piece: p2_piece, dsel: p2_dsel, dlin: p2_dlin}),
    .valid_o(c_v), .q_o(c_x), .side_o(c_side)
  );

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_dfv (
    .clk(clk), .rst(rst), .en(en), .valid_i(p2_v),
    .n_i(p2_dnum), .d_i(y_off), .side_i(1'b0),
    .valid_o(), .q_o(c_dq), .side_o()
  );

  // ---------------------------------------------------------------------
  // Q1: square x, settle slope.  Q2: force-length value.
  // R1..R4: force * FL * slope, one multiply and one shift per stage pair.
  // ---------------------------------------------------------------------
  logic                   q1_v, q2_v, r1_v, r2_v, r3_v, r4_v;
  logic signed [2*DW-1:0] q1_prod;
  logic signed [DW-1:0]   q1_dfv, q1_force, q1_vden;
  logic                   q1_in_rng, q1_outer;
  logic signed [DW-1:0]   q2_fl, q2_dfv, q2_force, q2_vden;
  logic signed [2*DW-1:0] r1_prod, r3_prod;
  logic signed [DW-1:0]   r1_dfv, r1_vden, r2_t, r2_dfv, r2_vden, r3_vden;
  logic signed [DW-1:0]   r4_t, r4_vden;

  logic signed [DW-1:0] dfv_c, half_c, fl_c;

  always_comb begin
    case (c_side.dsel)
      DFV_LINEAR: dfv_c = c_side.dlin;
      DFV_DIV:    dfv_c = c_dq;
      default:    dfv_c = '0;
    endcase

    half_c = mulsat(q1_prod) >>> 1;
    if (!q1_in_rng) begin
      fl_c = '0;
    end else if (q1_outer) begin
      fl_c = half_c;
    end else begin
      fl_c = sub_sat(ONE_Q, half_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_prod   <= c_x * c_x;
      q1_dfv    <= dfv_c;
      q1_in_rng <= c_side.in_rng;
      q1_outer  <= (c_side.piece == PC_RISE) || (c_side.piece == PC_FALL);
      q1_force  <= c_side.force_v;
      q1_vden   <= c_side.vden;

      q2_fl     <= fl_c;
      q2_dfv    <= q1_dfv;
      q2_force  <= q1_force;
      q2_vden   <= q1_vden;

      r1_prod   <= q2_force * q2_fl;
      r1_dfv    <= q2_dfv;
      r1_vden   <= q2_vden;

      r2_t      <= mulsat(r1_prod);
      r2_dfv    <= r1_dfv;
      r2_vden   <= r1_vden;

      r3_prod   <= r2_t * r2_dfv;
      r3_vden   <= r2_vden;

      r4_t      <= mulsat(r3_prod);
      r4_vden   <= r3_vden;
    end
  end

  // ---------------------------------------------------------------------
  // Divide D: scale by the velocity denominator, then negate into the
  // result register.
  // ---------------------------------------------------------------------
  logic                 d_v;
  logic signed [DW-1:0] d_q;

  mgvd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_out (
    .clk(clk), .rst(rst), .en(en), .valid_i(r4_v),
    .n_i(r4_t), .d_i(r4_vden), .side_i(1'b0),
    .valid_o(d_v), .q_o(d_q), .side_o()
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= (d_q == S_MIN) ? S_MAX : -d_q;
    end
  end

  // Valid bits travel with the data; clear them on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v  <= 1'b0;
      m2_v  <= 1'b0;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      q1_v  <= 1'b0;
      q2_v  <= 1'b0;
      r1_v  <= 1'b0;
      r2_v  <= 1'b0;
      r3_v  <= 1'b0;
      r4_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      m1_v  <= a_v;
      m2_v  <= m1_v;
      p1_v  <= b_v;
      p2_v  <= p1_v;
      q1_v  <= c_v;
      q2_v  <= q1_v;
      r1_v  <= q2_v;
      r2_v  <= r1_v;
      r3_v  <= r2_v;
      r4_v  <= r3_v;
      out_v <= d_v;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_below_min: assert property (@(posedge clk) disable iff (rst)
    (p1_v && en && p1_lnorm < l_min) |=> !p2_in_rng)
    else $error("length below curve start marked in range");

  a_fl_zero: assert property (@(posedge clk) disable iff (rst)
    (q1_v && en && !q1_in_rng) |=> q2_fl == '0)
    else $error("force-length value nonzero outside curve");

  a_dfv_zero: assert property (@(posedge clk) disable iff (rst)
    (c_v && en && c_side.dsel == DFV_ZERO) |=> q1_dfv == '0)
    else $error("velocity slope nonzero beyond limits");

endmodule
